/* rtl/core/trr_pkg.sv */
// ----------------------------------------------------------------------------
// trr_pkg: shared definitions for the textured triangle rasterizer
// Field widths, register map, operation codes and the sequencer states.
// ----------------------------------------------------------------------------
package trr_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned AREA_W     = 36;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned PROD_W     = AREA_W + DIFF_W;
  localparam int unsigned SUM_W      = 55;
  localparam int unsigned QUOT_W     = SUM_W + 1;
  localparam int unsigned OUT_DATA_W = 152;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic KIND_BOX   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [1:0] SLOT_LAST = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  localparam logic [1:0] REG_CANVAS_W  = 2'd0;
  localparam logic [1:0] REG_CANVAS_H  = 2'd1;
  localparam logic [1:0] REG_TEXTURE_W = 2'd2;
  localparam logic [1:0] REG_TEXTURE_H = 2'd3;

  localparam logic [3:0] STEP_AREA_END = 4'd1;
  localparam logic [3:0] STEP_W2_END   = 4'd3;
  localparam logic [3:0] STEP_EDGE_END = 4'd5;
  localparam logic [3:0] STEP_SU_END   = 4'd8;
  localparam logic [3:0] STEP_LAST     = 4'd11;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

/* rtl/core/textured_triangle_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// textured_triangle_rasterizer_top
// Edge-function triangle set-up and pixel test with barycentric u/v, built
// around one shared multiply-accumulate unit and one radix-2 divider.
// ----------------------------------------------------------------------------
// A vertex load of slot 0, 1 or 3 is done in the idle state; a slot 2 load
// runs two multiply-accumulate steps. A pixel test goes straight to the
// result when degenerate, stops after the edge check when not covered, and
// when covered runs twelve multiplier steps and two 55-step divisions.
// One item is in flight at a time; the next is taken once the result beat
// has left. Reset is asynchronous, active low, and restores the registers.
module textured_triangle_rasterizer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tuser: opcode[0], vertex_slot[2:1]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [2:0]   s_axis_tuser,
  // tdata: pos_x[15:0], pos_y[31:16], tex_u_in[47:32], tex_v_in[63:48]
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tuser: result_kind[0]
  output logic         m_axis_tuser,
  // tdata: box_min_x[14:0], box_min_y[29:15], box_max_x[45:30],
  // box_max_y[61:46], degenerate[62], pixel_x[78:63], pixel_y[94:79],
  // covered[95], tex_u_out[111:96], tex_v_out[127:112], in_texture[128],
  // zero fill [151:129]
  output logic [trr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned CB = trr_pkg::COORD_BITS;
  localparam int unsigned AW = trr_pkg::AREA_W;
  localparam int unsigned DW = trr_pkg::DIFF_W;
  localparam int unsigned PW = trr_pkg::PROD_W;
  localparam int unsigned SW = trr_pkg::SUM_W;
  localparam int unsigned QW = trr_pkg::QUOT_W;

  // Configuration registers.
  logic [14:0] cw_q, ch_q, tw_q, th_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 15'd320;
      ch_q <= 15'd240;
      tw_q <= 15'd256;
      th_q <= 15'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        trr_pkg::REG_CANVAS_W:  cw_q <= pwdata[14:0];
        trr_pkg::REG_CANVAS_H:  ch_q <= pwdata[14:0];
        trr_pkg::REG_TEXTURE_W: tw_q <= pwdata[14:0];
        trr_pkg::REG_TEXTURE_H: th_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      trr_pkg::REG_CANVAS_W:  prdata = {17'd0, cw_q};
      trr_pkg::REG_CANVAS_H:  prdata = {17'd0, ch_q};
      trr_pkg::REG_TEXTURE_W: prdata = {17'd0, tw_q};
      trr_pkg::REG_TEXTURE_H: prdata = {17'd0, th_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Input fields.
  logic              in_op;
  logic [1:0]        in_slot;
  logic signed [15:0] in_x, in_y;
  logic              in_acc;

  assign in_op   = s_axis_tuser[0];
  assign in_slot = s_axis_tuser[2:1];
  assign in_x    = 16'(signed'(s_axis_tdata[CB-1:0]));
  assign in_y    = 16'(signed'(s_axis_tdata[16+CB-1:16]));
  assign in_acc  = s_axis_tvalid & s_axis_tready;

  // Vertex store and sequencer state.
  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic signed [15:0] vu_q [3];
  logic signed [15:0] vv_q [3];
  logic signed [AW-1:0] area_q, w1_q, w2_q, w3_q;
  logic signed [SW-1:0] acc_q, su_q, sv_q;
  logic signed [15:0] pt_x_q, pt_y_q;
  logic               pixel_q, cov_q, div_v_q, qneg_q;
  logic [3:0]         step_q;
  logic [5:0]         dcnt_q;
  logic [SW-1:0]      dq_q;
  logic [AW:0]        rem_q;
  logic [AW-1:0]      dvs;
  logic signed [QW-1:0] qu_q, qv_q;
  trr_pkg::state_e    state_q;
  logic               m_valid_q;
  logic               m_kind_q;
  logic [trr_pkg::OUT_DATA_W-1:0] m_data_q;

  assign s_axis_tready = (state_q == trr_pkg::ST_IDLE) & ~m_valid_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = m_data_q;

  // Shared multiply-accumulate unit: operand selection per step.
  logic signed [AW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic                 op_sub, op_first;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] acc_d;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sub = 1'b0;
    op_first = 1'b0;
    case (step_q)
      4'd0: begin
        op_a = AW'(DW'(pt_x_q) - DW'(vx_q[1])); op_b = DW'(vy_q[2]) - DW'(vy_q[1]);
        op_first = 1'b1;
      end
      4'd1: begin
        op_a = AW'(DW'(pt_y_q) - DW'(vy_q[1])); op_b = DW'(vx_q[2]) - DW'(vx_q[1]);
        op_sub = 1'b1;
      end
      4'd2: begin
        op_a = AW'(DW'(pt_x_q) - DW'(vx_q[2])); op_b = DW'(vy_q[0]) - DW'(vy_q[2]);
        op_first = 1'b1;
      end
      4'd3: begin
        op_a = AW'(DW'(pt_y_q) - DW'(vy_q[2])); op_b = DW'(vx_q[0]) - DW'(vx_q[2]);
        op_sub = 1'b1;
      end
      4'd4: begin
        op_a = AW'(DW'(pt_x_q) - DW'(vx_q[0])); op_b = DW'(vy_q[1]) - DW'(vy_q[0]);
        op_first = 1'b1;
      end
      4'd5: begin
        op_a = AW'(DW'(pt_y_q) - DW'(vy_q[0])); op_b = DW'(vx_q[1]) - DW'(vx_q[0]);
        op_sub = 1'b1;
      end
      4'd6:  begin op_a = w1_q; op_b = DW'(vu_q[0]); op_first = 1'b1; end
      4'd7:  begin op_a = w2_q; op_b = DW'(vu_q[1]); end
      4'd8:  begin op_a = w3_q; op_b = DW'(vu_q[2]); end
      4'd9:  begin op_a = w1_q; op_b = DW'(vv_q[0]); op_first = 1'b1; end
      4'd10: begin op_a = w2_q; op_b = DW'(vv_q[1]); end
      4'd11: begin op_a = w3_q; op_b = DW'(vv_q[2]); end
      default: ;
    endcase
    prod  = PW'(op_a) * PW'(op_b);
    acc_d = (op_first ? SW'(0) : acc_q) + (op_sub ? -SW'(prod) : SW'(prod));
  end

  // Restoring divider step on magnitudes.
  logic [AW:0] rem_sh;
  logic        rem_ge;

  assign dvs    = area_q[AW-1] ? AW'(-area_q) : AW'(area_q);
  assign rem_sh = {rem_q[AW-1:0], dq_q[SW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs};

  // Edge sign test.
  logic cov_d;
  assign cov_d = (~w1_q[AW-1] & ~w2_q[AW-1] & ~w3_q[AW-1]) |
                 ((w1_q[AW-1] | w1_q == '0) & (w2_q[AW-1] | w2_q == '0) &
                  (w3_q[AW-1] | w3_q == '0));

  // Bounding box, clipped to the canvas.
  logic signed [15:0] mnx, mny, mxx, mxy;
  logic signed [16:0] cwm1, chm1;
  logic [14:0]        bmnx, bmny;
  logic [15:0]        bmxx, bmxy;

  always_comb begin
    mnx = vx_q[0];
    if (vx_q[1] < mnx) mnx = vx_q[1];
    if (vx_q[2] < mnx) mnx = vx_q[2];
    mny = vy_q[0];
    if (vy_q[1] < mny) mny = vy_q[1];
    if (vy_q[2] < mny) mny = vy_q[2];
    mxx = vx_q[0];
    if (vx_q[1] > mxx) mxx = vx_q[1];
    if (vx_q[2] > mxx) mxx = vx_q[2];
    mxy = vy_q[0];
    if (vy_q[1] > mxy) mxy = vy_q[1];
    if (vy_q[2] > mxy) mxy = vy_q[2];
    cwm1 = signed'({2'b00, cw_q}) - 17'sd1;
    chm1 = signed'({2'b00, ch_q}) - 17'sd1;
    bmnx = mnx[15] ? 15'd0 : mnx[14:0];
    bmny = mny[15] ? 15'd0 : mny[14:0];
    bmxx = (17'(mxx) > cwm1) ? cwm1[15:0] : mxx;
    bmxy = (17'(mxy) > chm1) ? chm1[15:0] : mxy;
  end

  logic in_tex;
  assign in_tex = ~qu_q[QW-1] & (qu_q < QW'(tw_q)) & ~qv_q[QW-1] & (qv_q < QW'(th_q));

  logic [QW-1:0] qmag;
  assign qmag = {1'b0, dq_q[SW-2:0], rem_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= trr_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      step_q    <= '0;
      dcnt_q    <= '0;
      area_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0; vy_q[i] <= '0; vu_q[i] <= '0; vv_q[i] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        trr_pkg::ST_IDLE: begin
          if (in_acc) begin
            step_q  <= '0;
            pixel_q <= in_op;
            cov_q   <= 1'b0;
            qu_q    <= '0;
            qv_q    <= '0;
            if (in_op == trr_pkg::OP_LOAD) begin
              if (in_slot != trr_pkg::SLOT_NONE) begin
                vx_q[in_slot] <= in_x;
                vy_q[in_slot] <= in_y;
                vu_q[in_slot] <= s_axis_tdata[47:32];
                vv_q[in_slot] <= s_axis_tdata[63:48];
              end
              pt_x_q <= vx_q[0];
              pt_y_q <= vy_q[0];
              if (in_slot == trr_pkg::SLOT_LAST) state_q <= trr_pkg::ST_MUL;
            end else begin
              pt_x_q  <= in_x;
              pt_y_q  <= in_y;
              state_q <= (area_q == '0) ? trr_pkg::ST_FIN : trr_pkg::ST_MUL;
            end
          end
        end
        trr_pkg::ST_MUL: begin
          acc_q  <= acc_d;
          step_q <= step_q + 4'd1;
          case (step_q)
            trr_pkg::STEP_AREA_END: begin
              if (!pixel_q) begin
                area_q  <= acc_d[AW-1:0];
                state_q <= trr_pkg::ST_FIN;
              end else begin
                w1_q <= acc_d[AW-1:0];
              end
            end
            trr_pkg::STEP_W2_END: w2_q <= acc_d[AW-1:0];
            trr_pkg::STEP_EDGE_END: begin
              w3_q    <= acc_d[AW-1:0];
              state_q <= trr_pkg::ST_CHK;
            end
            trr_pkg::STEP_SU_END: su_q <= acc_d;
            trr_pkg::STEP_LAST: begin
              sv_q    <= acc_d;
              dq_q    <= SW'(su_q[SW-1] ? -su_q : su_q);
              qneg_q  <= su_q[SW-1] ^ area_q[AW-1];
              rem_q   <= '0;
              dcnt_q  <= '0;
              div_v_q <= 1'b0;
              state_q <= trr_pkg::ST_DIV;
            end
            default: ;
          endcase
        end
        trr_pkg::ST_CHK: begin
          cov_q   <= cov_d;
          state_q <= cov_d ? trr_pkg::ST_MUL : trr_pkg::ST_FIN;
        end
        trr_pkg::ST_DIV: begin
          if (dcnt_q == 6'(SW - 1)) begin
            dcnt_q <= '0;
            rem_q  <= '0;
            if (!div_v_q) begin
              qu_q    <= qneg_q ? -qmag : qmag;
              dq_q    <= SW'(sv_q[SW-1] ? -sv_q : sv_q);
              qneg_q  <= sv_q[SW-1] ^ area_q[AW-1];
              div_v_q <= 1'b1;
            end else begin
              qv_q    <= qneg_q ? -qmag : qmag;
              state_q <= trr_pkg::ST_FIN;
            end
          end else begin
            rem_q  <= rem_ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
            dq_q   <= {dq_q[SW-2:0], rem_ge};
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        trr_pkg::ST_FIN: begin
          m_valid_q <= 1'b1;
          m_data_q  <= '0;
          if (!pixel_q) begin
            m_kind_q        <= trr_pkg::KIND_BOX;
            m_data_q[14:0]  <= bmnx;
            m_data_q[29:15] <= bmny;
            m_data_q[45:30] <= bmxx;
            m_data_q[61:46] <= bmxy;
            m_data_q[62]    <= (area_q == '0);
          end else begin
            m_kind_q          <= trr_pkg::KIND_PIXEL;
            m_data_q[62]      <= (area_q == '0);
            m_data_q[78:63]   <= pt_x_q;
            m_data_q[94:79]   <= pt_y_q;
            m_data_q[95]      <= cov_q;
            m_data_q[111:96]  <= qu_q[15:0];
            m_data_q[127:112] <= qv_q[15:0];
            m_data_q[128]     <= cov_q & in_tex;
          end
          state_q <= trr_pkg::ST_IDLE;
        end
        default: state_q <= trr_pkg::ST_IDLE;
      endcase
    end
  end

  // A waiting result beat blocks new input.
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !s_axis_tready) else $error("input accepted with result pending");

  // Coverage is never reported for a degenerate triangle.
  a_cov_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[95] && m_data_q[62])) else $error("degenerate covered");

  // The texture hit implies coverage.
  a_tex_needs_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[128] |-> m_data_q[95]) else $error("in_texture without cover");

  // The divider only runs on a covered pixel.
  a_div_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == trr_pkg::ST_DIV |-> cov_q && pixel_q) else $error("divide without cover");

endmodule

/* tb/raster_checker.sv */
// ----------------------------------------------------------------------------
// raster_checker: result predictor and comparator for the rasterizer
// Watches the register port and both streams, keeps its own copy of the
// vertices, area and registers, and predicts each box or pixel result.
// ----------------------------------------------------------------------------
module raster_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [2:0]   s_axis_tuser,
  input  logic [63:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         m_axis_tuser,
  input  logic [trr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               kind;
    logic [14:0]        min_x;
    logic [14:0]        min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic               degen;
    logic signed [15:0] pix_x;
    logic signed [15:0] pix_y;
    logic               covered;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic               in_tex;
  } raster_result_t;

  raster_result_t expected_results[$];

  longint canvas_w, canvas_h, tex_w, tex_h;
  longint vert_x[3], vert_y[3], vert_u[3], vert_v[3];
  longint area2;
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  // Updates the vertex copy and returns 1 when the beat yields a result.
  function automatic bit rasterize_beat(input logic [2:0] user, input logic [63:0] data,
                                        output raster_result_t r);
    longint px, py, mnx, mny, mxx, mxy, w1, w2, w3, su, sv, qu, qv;
    logic [1:0] slot;
    r = '{default: '0};
    px = longint'($signed(data[15:0]));
    py = longint'($signed(data[31:16]));
    slot = user[2:1];
    if (user[0] == trr_pkg::OP_LOAD) begin
      if (slot == trr_pkg::SLOT_NONE) return 0;
      vert_x[slot] = px;
      vert_y[slot] = py;
      vert_u[slot] = longint'($signed(data[47:32]));
      vert_v[slot] = longint'($signed(data[63:48]));
      if (slot != trr_pkg::SLOT_LAST) return 0;
      area2 = (vert_x[0] - vert_x[1]) * (vert_y[2] - vert_y[1])
            - (vert_y[0] - vert_y[1]) * (vert_x[2] - vert_x[1]);
      mnx = min3(vert_x[0], vert_x[1], vert_x[2]);
      mny = min3(vert_y[0], vert_y[1], vert_y[2]);
      mxx = max3(vert_x[0], vert_x[1], vert_x[2]);
      mxy = max3(vert_y[0], vert_y[1], vert_y[2]);
      if (mnx < 0) mnx = 0;
      if (mny < 0) mny = 0;
      if (mxx > canvas_w - 1) mxx = canvas_w - 1;
      if (mxy > canvas_h - 1) mxy = canvas_h - 1;
      r.kind  = trr_pkg::KIND_BOX;
      r.min_x = mnx[14:0];
      r.min_y = mny[14:0];
      r.max_x = mxx[15:0];
      r.max_y = mxy[15:0];
      r.degen = (area2 == 0);
      return 1;
    end
    r.kind  = trr_pkg::KIND_PIXEL;
    r.degen = (area2 == 0);
    r.pix_x = px[15:0];
    r.pix_y = py[15:0];
    if (area2 != 0) begin
      w1 = (px - vert_x[1]) * (vert_y[2] - vert_y[1]) - (py - vert_y[1]) * (vert_x[2] - vert_x[1]);
      w2 = (px - vert_x[2]) * (vert_y[0] - vert_y[2]) - (py - vert_y[2]) * (vert_x[0] - vert_x[2]);
      w3 = (px - vert_x[0]) * (vert_y[1] - vert_y[0]) - (py - vert_y[0]) * (vert_x[1] - vert_x[0]);
      if ((w1 >= 0 && w2 >= 0 && w3 >= 0) || (w1 <= 0 && w2 <= 0 && w3 <= 0)) begin
        su = w1 * vert_u[0] + w2 * vert_u[1] + w3 * vert_u[2];
        sv = w1 * vert_v[0] + w2 * vert_v[1] + w3 * vert_v[2];
        qu = su / area2;
        qv = sv / area2;
        r.covered = 1'b1;
        r.tex_u   = qu[15:0];
        r.tex_v   = qv[15:0];
        r.in_tex  = qu >= 0 && qu < tex_w && qv >= 0 && qv < tex_h;
      end
    end
    return 1;
  endfunction

  function automatic void check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    raster_result_t r, e;
    logic [trr_pkg::OUT_DATA_W-1:0] d;
    if (!rst_ni) begin
      canvas_w = 320;
      canvas_h = 240;
      tex_w    = 256;
      tex_h    = 256;
      for (int i = 0; i < 3; i++) begin
        vert_x[i] = 0; vert_y[i] = 0; vert_u[i] = 0; vert_v[i] = 0;
      end
      area2 = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          trr_pkg::REG_CANVAS_W:  canvas_w = pwdata[14:0];
          trr_pkg::REG_CANVAS_H:  canvas_h = pwdata[14:0];
          trr_pkg::REG_TEXTURE_W: tex_w    = pwdata[14:0];
          trr_pkg::REG_TEXTURE_H: tex_h    = pwdata[14:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (rasterize_beat(s_axis_tuser, s_axis_tdata, r)) expected_results.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("result_kind", e.kind, m_axis_tuser);
          check_field("box_min_x", e.min_x, d[14:0]);
          check_field("box_min_y", e.min_y, d[29:15]);
          check_field("box_max_x", e.max_x, $signed(d[45:30]));
          check_field("box_max_y", e.max_y, $signed(d[61:46]));
          check_field("degenerate", e.degen, d[62]);
          check_field("pixel_x", e.pix_x, $signed(d[78:63]));
          check_field("pixel_y", e.pix_y, $signed(d[94:79]));
          check_field("covered", e.covered, d[95]);
          check_field("tex_u_out", e.tex_u, $signed(d[111:96]));
          check_field("tex_v_out", e.tex_v, $signed(d[127:112]));
          check_field("in_texture", e.in_tex, d[128]);
          check_field("zero_fill", 0, d[151:129]);
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the textured triangle rasterizer
// Loads triangles and tests pixels against them under several idling
// patterns and register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [2:0]   s_axis_tuser;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [trr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;
  int beats_sent;

  textured_triangle_rasterizer_top u_dut (.*);

  raster_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(logic op, logic [1:0] slot, logic [15:0] x, logic [15:0] y,
                           logic [15:0] u, logic [15:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {slot, op};
    s_axis_tdata  <= {v, u, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the block drain so that the registers may be changed safely.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] cw, logic [31:0] ch, logic [31:0] tw,
                          logic [31:0] th);
    drain();
    write_reg(trr_pkg::REG_CANVAS_W, cw);
    write_reg(trr_pkg::REG_CANVAS_H, ch);
    write_reg(trr_pkg::REG_TEXTURE_W, tw);
    write_reg(trr_pkg::REG_TEXTURE_H, th);
  endtask

  function automatic logic [15:0] near(int centre, int span);
    int val;
    val = centre + $urandom_range(2 * span) - span;
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    return val[15:0];
  endfunction

  // One well-formed triangle with random texture, followed by pixel tests
  // inside its bounding box.
  task automatic random_triangle();
    int cx, cy, span, tspan, npix;
    logic [15:0] vx[3], vy[3];
    int lox, hix, loy, hiy;
    cx = $urandom_range(3) == 0 ? int'($signed(16'($urandom))) : $urandom_range(400) - 40;
    cy = $urandom_range(3) == 0 ? int'($signed(16'($urandom))) : $urandom_range(300) - 30;
    span  = $urandom_range(7) == 0 ? 32767 : $urandom_range(60) + 1;
    tspan = $urandom_range(3) == 0 ? 32767 : 300;
    for (int i = 0; i < 3; i++) begin
      vx[i] = near(cx, span);
      vy[i] = near(cy, span);
      send_beat(trr_pkg::OP_LOAD, 2'(i), vx[i], vy[i], near(120, tspan), near(120, tspan));
    end
    lox = int'($signed(vx[0])); hix = lox; loy = int'($signed(vy[0])); hiy = loy;
    for (int i = 1; i < 3; i++) begin
      if (int'($signed(vx[i])) < lox) lox = int'($signed(vx[i]));
      if (int'($signed(vx[i])) > hix) hix = int'($signed(vx[i]));
      if (int'($signed(vy[i])) < loy) loy = int'($signed(vy[i]));
      if (int'($signed(vy[i])) > hiy) hiy = int'($signed(vy[i]));
    end
    npix = $urandom_range(6) + 1;
    for (int i = 0; i < npix; i++) begin
      send_beat(trr_pkg::OP_PIXEL, 2'($urandom), 16'($urandom_range(hix - lox) + lox),
                16'($urandom_range(hiy - loy) + loy), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = beats_sent;
    while (beats_sent - start < count) begin
      case ($urandom_range(9))
        0: send_beat(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        // Broken sequence: a lone vertex update then tests against a stale area.
        1: begin
          send_beat(trr_pkg::OP_LOAD, 2'($urandom_range(1)), near(100, 80), near(100, 80),
                    16'($urandom), 16'($urandom));
          send_beat(trr_pkg::OP_PIXEL, 2'd0, near(100, 80), near(100, 80), 16'h0, 16'h0);
        end
        default: random_triangle();
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    beats_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, pixel on the all-zero (degenerate) triangle.
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(trr_pkg::OP_LOAD, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(trr_pkg::OP_LOAD, 2'd1, 16'd100, 16'h0000, 16'd255, 16'h0000);
    send_beat(trr_pkg::OP_LOAD, 2'd2, 16'h0000, 16'd100, 16'h0000, 16'd255);
    send_beat(trr_pkg::OP_PIXEL, 2'd3, 16'd10, 16'd10, 16'hFFFF, 16'hFFFF);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'd100, 16'd0, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'd90, 16'd90, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_LOAD, trr_pkg::SLOT_NONE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    // Extreme vertices and texture coordinates.
    send_beat(trr_pkg::OP_LOAD, 2'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    send_beat(trr_pkg::OP_LOAD, 2'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_beat(trr_pkg::OP_LOAD, 2'd2, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h8000, 16'h8000, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h0000, 16'h0000, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_LOAD, 2'd2, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h0000, 16'h0000, 16'h0, 16'h0);
    // Stale area: move a vertex without reloading the last slot.
    send_beat(trr_pkg::OP_LOAD, 2'd0, 16'h0000, 16'h0000, 16'h0, 16'h0);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'h1000, 16'h1000, 16'h0, 16'h0);

    // Zero-sized canvas and texture registers, then the largest values.
    set_regs(32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(trr_pkg::OP_LOAD, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(trr_pkg::OP_LOAD, 2'd1, 16'd40, 16'd0, 16'd8, 16'd0);
    send_beat(trr_pkg::OP_LOAD, 2'd2, 16'd0, 16'd40, 16'd0, 16'd8);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'd5, 16'd5, 16'h0, 16'h0);
    set_regs(32'hFFFF_7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
    send_beat(trr_pkg::OP_LOAD, 2'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(trr_pkg::OP_PIXEL, 2'd0, 16'd10, 16'd10, 16'h0, 16'h0);

    // Random phases under the four idling patterns.
    set_regs(320, 240, 256, 256);
    random_phase(450);
    set_regs(1, 1, 1, 1);
    send_idle_pct = 75;
    random_phase(450);
    set_regs($urandom_range(32767, 1), $urandom_range(32767, 1),
             $urandom_range(400, 1), $urandom_range(400, 1));
    send_idle_pct = 0;
    recv_stall_pct = 75;
    random_phase(450);
    set_regs(640, 480, 64, 128);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    hold_request = 1'b1;
    random_phase(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(100);

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
